@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the HSV to RGB565 pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst_n is low.
`define HSV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds whenever a qualifier is high.
`define HSV_ASSERT_WHEN(name, qual, cond, msg) \
    `HSV_ASSERT(name, (qual) |-> (cond), msg)

`endif

@@ design/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants and stage payload types of the HSV to RGB565 pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_W   = 15;
    localparam int CHAN_W  = 8;
    localparam int REM_W   = 12;
    localparam int NUM_W   = 20;
    localparam int SECT_W  = 4;

    // One 60 degree sector in 1/64 degree units: 60 * 64 = 15 << 8.
    localparam logic [REM_W-1:0] SECTOR_SPAN = 12'd3840;
    // Denominator of q and t: 255 * SECTOR_SPAN = 3825 << 8.
    localparam logic [NUM_W-1:0] FULL_SCALE  = 20'd979200;
    // Divisor left after the shift by 8.
    localparam logic [NUM_W-1:0] QT_DIV      = 20'd3825;
    // Reciprocal estimates: floor(2^20 / 3825) and floor(2^16 / 255).
    localparam logic [27:0]      QT_RECIP    = 28'd274;
    localparam logic [23:0]      P_RECIP     = 24'd257;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

    // Sector codes; anything above SEC_RISE_R takes the default order.
    localparam logic [SECT_W-1:0] SEC_RISE_G = 4'd0;
    localparam logic [SECT_W-1:0] SEC_FALL_R = 4'd1;
    localparam logic [SECT_W-1:0] SEC_RISE_B = 4'd2;
    localparam logic [SECT_W-1:0] SEC_FALL_G = 4'd3;
    localparam logic [SECT_W-1:0] SEC_RISE_R = 4'd4;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [REM_W-1:0]  rem;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bright;
    } sec_t;

    typedef struct packed {
        logic [SECT_W-1:0] sector;
        logic [CHAN_W-1:0] bright;
        logic [NUM_W-1:0]  yq;
        logic [NUM_W-1:0]  yt;
        logic [15:0]       ps;
        logic [CHAN_W-1:0] pe;
    } prod_t;

endpackage

@@ design/hsv_to_rgb565_pixel.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb565_pixel
// Throughput: one pixel per cycle; all five stages advance together and
// freeze only while the output beat is held by a low m_tready.
// Reset: rst_n clears every stage valid bit at once; payload is not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb565_pixel (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue_fixed[14:0], saturation[22:15], brightness[30:23], 0
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // red[7:0], green[15:8], blue[23:16], packed565[39:24]
);
    import hsvrgb_pkg::*;

    logic              adv;
    logic              sec_valid;
    sec_t              sec_data;
    logic              prod_valid;
    prod_t             prod_data;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [15:0]       packed565;

    // Advance the whole pipe whenever the output slot is empty or being taken;
    // bubbles ride along, so a stall holds every stage in place.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage 1: sector and remainder.
    hsvrgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .hue_fixed  (s_tdata[14:0]),
        .saturation (s_tdata[22:15]),
        .brightness (s_tdata[30:23]),
        .out_valid  (sec_valid),
        .out_data   (sec_data)
    );

    // Stages 2 and 3: numerators and scaling by value.
    hsvrgb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sec_valid),
        .in_data   (sec_data),
        .out_valid (prod_valid),
        .out_data  (prod_data)
    );

    // Stages 4 and 5: exact floors, channel order, output register.
    hsvrgb_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (prod_valid),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .packed565 (packed565)
    );

    assign m_tdata = {packed565, blue, green, red};

endmodule

@@ design/hsvrgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Stage 1: split the hue into a 60 degree sector and the remainder within it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsvrgb_sector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [hsvrgb_pkg::HUE_W-1:0]        hue_fixed,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]       saturation,
    input  logic [hsvrgb_pkg::CHAN_W-1:0]       brightness,
    output logic                                out_valid,
    output hsvrgb_pkg::sec_t                    out_data
);
    import hsvrgb_pkg::*;

    logic [6:0]  h8;
    logic [11:0] est_prod;
    logic [3:0]  est;
    logic [7:0]  r15;
    logic [3:0]  rem_hi;
    sec_t        sec_next;
    logic        valid_reg;
    sec_t        data_reg;

    // hue / 3840 == (hue >> 8) / 15; 17/256 underestimates 1/15 by under one.
    always_comb
    begin
        h8       = hue_fixed[14:8];
        est_prod = 12'(h8) * 12'd17;
        est      = est_prod[11:8];
        r15      = 8'(h8) - 8'(est) * 8'd15;
        sec_next.sat    = saturation;
        sec_next.bright = brightness;
        if (r15 >= 8'd15)
        begin
            sec_next.sector = est + 4'd1;
            rem_hi          = 4'(r15 - 8'd15);
        end
        else
        begin
            sec_next.sector = est;
            rem_hi          = r15[3:0];
        end
        sec_next.rem = {rem_hi, hue_fixed[7:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= sec_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `HSV_ASSERT_WHEN(a_rem_in_sector, valid_reg, data_reg.rem < SECTOR_SPAN, "rem too large")

endmodule

@@ design/hsvrgb_mult.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_mult
// Stages 2 and 3: form the p, q and t numerators and scale them by value.
// ----------------------------------------------------------------------------
module hsvrgb_mult (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  hsvrgb_pkg::sec_t     in_data,
    output logic                 out_valid,
    output hsvrgb_pkg::prod_t    out_data
);
    import hsvrgb_pkg::*;

    logic [REM_W-1:0]  comp;
    logic [NUM_W-1:0]  sr_q;
    logic [NUM_W-1:0]  sr_t;
    logic [27:0]       xq;
    logic [27:0]       xt;
    logic [23:0]       pe_prod;
    prod_t             prod_next;

    logic              s2_valid_reg;
    logic [SECT_W-1:0] s2_sector_reg;
    logic [CHAN_W-1:0] s2_bright_reg;
    logic [NUM_W-1:0]  s2_numq_reg;
    logic [NUM_W-1:0]  s2_numt_reg;
    logic [15:0]       s2_ps_reg;
    logic              s3_valid_reg;
    prod_t             s3_data_reg;

    // Stage 2: s * r, s * (D - r) and v * (255 - s).
    always_comb
    begin
        comp = SECTOR_SPAN - in_data.rem;
        sr_q = NUM_W'(in_data.sat) * NUM_W'(in_data.rem);
        sr_t = NUM_W'(in_data.sat) * NUM_W'(comp);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sector_reg <= in_data.sector;
            s2_bright_reg <= in_data.bright;
            s2_numq_reg   <= FULL_SCALE - sr_q;
            s2_numt_reg   <= FULL_SCALE - sr_t;
            s2_ps_reg     <= 16'(in_data.bright) * 16'(CHAN_MAX - in_data.sat);
        end
    end

    // Stage 3: scale by value, drop the power-of-two part of the divisor,
    // estimate p by reciprocal.
    always_comb
    begin
        xq      = 28'(s2_bright_reg) * 28'(s2_numq_reg);
        xt      = 28'(s2_bright_reg) * 28'(s2_numt_reg);
        pe_prod = 24'(s2_ps_reg) * P_RECIP;
        prod_next.sector = s2_sector_reg;
        prod_next.bright = s2_bright_reg;
        prod_next.yq     = xq[27:8];
        prod_next.yt     = xt[27:8];
        prod_next.ps     = s2_ps_reg;
        prod_next.pe     = pe_prod[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s3_data_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

@@ design/hsvrgb_norm.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_norm
// Stages 4 and 5: finish the divisions, order the channels, pack RGB565.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsvrgb_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  hsvrgb_pkg::prod_t                 in_data,
    output logic                              out_valid,
    output logic [hsvrgb_pkg::CHAN_W-1:0]     red,
    output logic [hsvrgb_pkg::CHAN_W-1:0]     green,
    output logic [hsvrgb_pkg::CHAN_W-1:0]     blue,
    output logic [15:0]                       packed565
);
    import hsvrgb_pkg::*;

    logic [27:0]       qprod;
    logic [27:0]       tprod;
    logic [16:0]       pr;
    logic [CHAN_W-1:0] p_next;

    logic              s4_valid_reg;
    logic [SECT_W-1:0] s4_sector_reg;
    logic [CHAN_W-1:0] s4_bright_reg;
    logic [NUM_W-1:0]  s4_yq_reg;
    logic [NUM_W-1:0]  s4_yt_reg;
    logic [CHAN_W-1:0] s4_qe_reg;
    logic [CHAN_W-1:0] s4_te_reg;
    logic [CHAN_W-1:0] s4_p_reg;

    logic [NUM_W-1:0]  rq;
    logic [NUM_W-1:0]  rt;
    logic [CHAN_W-1:0] q_val;
    logic [CHAN_W-1:0] t_val;
    logic [CHAN_W-1:0] r_next;
    logic [CHAN_W-1:0] g_next;
    logic [CHAN_W-1:0] b_next;

    logic              valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [15:0]       packed_reg;
    logic [15:0]       pack_chk;

    // Stage 4: quotient estimates for q and t, exact p.
    always_comb
    begin
        qprod  = 28'(in_data.yq) * QT_RECIP;
        tprod  = 28'(in_data.yt) * QT_RECIP;
        pr     = 17'(in_data.ps) - 17'(in_data.pe) * 17'(CHAN_MAX);
        p_next = (pr >= 17'(CHAN_MAX)) ? in_data.pe + 8'd1 : in_data.pe;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sector_reg <= in_data.sector;
            s4_bright_reg <= in_data.bright;
            s4_yq_reg     <= in_data.yq;
            s4_yt_reg     <= in_data.yt;
            s4_qe_reg     <= qprod[27:20];
            s4_te_reg     <= tprod[27:20];
            s4_p_reg      <= p_next;
        end
    end

    // Stage 5: correct the estimates by one where the remainder overflows, then order the channels.
    always_comb
    begin
        rq    = s4_yq_reg - NUM_W'(s4_qe_reg) * QT_DIV;
        rt    = s4_yt_reg - NUM_W'(s4_te_reg) * QT_DIV;
        q_val = (rq >= QT_DIV) ? s4_qe_reg + 8'd1 : s4_qe_reg;
        t_val = (rt >= QT_DIV) ? s4_te_reg + 8'd1 : s4_te_reg;
        unique case (s4_sector_reg)
            SEC_RISE_G:
            begin
                r_next = s4_bright_reg; g_next = t_val;         b_next = s4_p_reg;
            end
            SEC_FALL_R:
            begin
                r_next = q_val;         g_next = s4_bright_reg; b_next = s4_p_reg;
            end
            SEC_RISE_B:
            begin
                r_next = s4_p_reg;      g_next = s4_bright_reg; b_next = t_val;
            end
            SEC_FALL_G:
            begin
                r_next = s4_p_reg;      g_next = q_val;         b_next = s4_bright_reg;
            end
            SEC_RISE_R:
            begin
                r_next = t_val;         g_next = s4_p_reg;      b_next = s4_bright_reg;
            end
            default:
            begin
                r_next = s4_bright_reg; g_next = s4_p_reg;      b_next = q_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg    <= r_next;
            green_reg  <= g_next;
            blue_reg   <= b_next;
            packed_reg <= {r_next[7:3], g_next[7:2], b_next[7:3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= in_valid;
            valid_reg    <= s4_valid_reg;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign packed565 = packed_reg;

    // Repack the held channels to compare against the registered RGB565 word.
    assign pack_chk  = {red_reg[7:3], green_reg[7:2], blue_reg[7:3]};

    `HSV_ASSERT_WHEN(a_q_est_close, s4_valid_reg, rq < (QT_DIV << 1), "q estimate off")
    `HSV_ASSERT_WHEN(a_pack_match, valid_reg, packed_reg == pack_chk, "RGB565 mismatch")

endmodule
